[rtl/afpm_pkg.sv]
// Shared types and constants of the affine forward pixel mapper.
// Payload structs, configuration register file layout and register indexes.
// No dependencies.
package afpm_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 50;
	localparam int ADDR_W      = 34;
	localparam int STRIDE_W    = 18;
	localparam int HEIGHT_LSB  = 16;
	localparam int STRIDE_LSB  = 32;

	localparam logic [7:0]         ALPHA_OPAQUE = 8'hFF;
	localparam logic signed [31:0] INT32_MAX    = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] INT32_MIN    = 32'sh8000_0000;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_COEF_XX       = 3'd0,
		REG_COEF_XY       = 3'd1,
		REG_SHIFT_X       = 3'd2,
		REG_COEF_YX       = 3'd3,
		REG_COEF_YY       = 3'd4,
		REG_SHIFT_Y       = 3'd5,
		REG_SOURCE_SIZE   = 3'd6,
		REG_DEST_GEOMETRY = 3'd7
	} afpm_reg_t;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} afpm_src_t;

	typedef struct packed {
		logic [ADDR_W-1:0] dest_address;
		logic [7:0]        red_out;
		logic [7:0]        green_out;
		logic [7:0]        blue_out;
		logic [7:0]        alpha_out;
		logic              frame_last;
	} afpm_dst_t;

	// What the front end learns about a pixel besides its position.
	typedef struct packed {
		afpm_src_t pix;
		logic      first;
		logic      last;
	} afpm_tag_t;

	typedef struct packed {
		logic signed [31:0] coef_xx;
		logic signed [31:0] coef_xy;
		logic signed [31:0] shift_x;
		logic signed [31:0] coef_yx;
		logic signed [31:0] coef_yy;
		logic signed [31:0] shift_y;
		logic [31:0]        source_size;
		logic [49:0]        dest_geometry;
	} afpm_cfg_t;

	localparam afpm_cfg_t CFG_RESET = '{
		coef_xx:       32'sd65536,
		coef_xy:       32'sd0,
		shift_x:       32'sd0,
		coef_yx:       32'sd0,
		coef_yy:       32'sd65536,
		shift_y:       32'sd0,
		source_size:   32'd0,
		dest_geometry: 50'd0
	};

endpackage

[rtl/afpm_front.sv]
// Front end of the affine forward pixel mapper: accepts source pixels,
// tracks the raster position and marks first and last pixels of a frame.
// Depends on afpm_pkg.
module afpm_front #(
	parameter int COORD_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic                   q_full,
	input  afpm_pkg::afpm_src_t    source,
	input  logic [31:0]            source_size,
	output logic                   q_wr,
	output logic [COORD_BITS-1:0]  col,
	output logic [COORD_BITS-1:0]  row,
	output afpm_pkg::afpm_tag_t    tag
);
	import afpm_pkg::*;

	logic [COORD_BITS-1:0] col_q;
	logic [COORD_BITS-1:0] row_q;
	logic [COORD_BITS-1:0] src_w;
	logic [COORD_BITS-1:0] src_h;
	logic [COORD_BITS-1:0] w_lim;
	logic [COORD_BITS-1:0] h_lim;
	logic [COORD_BITS:0]   col_inc;
	logic [COORD_BITS:0]   row_inc;
	logic                  row_end;
	logic                  frame_end;

	always_comb begin
		src_w     = source_size[COORD_BITS-1:0];
		src_h     = source_size[HEIGHT_LSB +: COORD_BITS];
		// A zero size behaves as a size of one.
		w_lim     = (src_w == '0) ? COORD_BITS'(1) : src_w;
		h_lim     = (src_h == '0) ? COORD_BITS'(1) : src_h;
		col_inc   = (COORD_BITS+1)'(col_q) + (COORD_BITS+1)'(1);
		row_inc   = (COORD_BITS+1)'(row_q) + (COORD_BITS+1)'(1);
		row_end   = (col_inc >= (COORD_BITS+1)'(w_lim));
		frame_end = row_end && (row_inc >= (COORD_BITS+1)'(h_lim));
		q_wr      = push && !q_full;
		col       = col_q;
		row       = row_q;
		tag.pix   = source;
		tag.first = (col_q == '0) && (row_q == '0);
		tag.last  = frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (q_wr) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_inc[COORD_BITS-1:0];
			end else begin
				col_q <= col_inc[COORD_BITS-1:0];
			end
		end
	end

endmodule

[rtl/afpm_queue.sv]
// Short first-in first-out queue between front and back end of the mapper.
// Generic width and depth; no package dependencies.
module afpm_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [IDX_W-1:0] wr_ptr_q;
	logic [IDX_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_q + IDX_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_q + IDX_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

[rtl/afpm_back.sv]
// Back end of the affine forward pixel mapper: a sequencer around one pair of
// multipliers that centres the frame, maps, clamps and forms the byte address.
// Depends on afpm_pkg.
module afpm_back #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	output logic                  q_rd,
	input  logic [COORD_BITS-1:0] col,
	input  logic [COORD_BITS-1:0] row,
	input  afpm_pkg::afpm_tag_t   tag,
	input  afpm_pkg::afpm_cfg_t   cfg,
	input  logic                  pop,
	output logic                  empty,
	output afpm_pkg::afpm_dst_t   dest
);
	import afpm_pkg::*;

	localparam int PROD_W = 33 + COORD_BITS;
	localparam int SUM_W  = PROD_W + 3;
	localparam logic signed [SUM_W-1:0] ONE_W  = SUM_W'(1) << FRAC_BITS;
	localparam logic signed [SUM_W-1:0] BIAS_W = (ONE_W <<< 1) - SUM_W'(1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_C_MUL,
		ST_C_SUM,
		ST_C_DIV,
		ST_C_SAT,
		ST_M_MUL,
		ST_M_SUM,
		ST_M_CLP,
		ST_A_MUL,
		ST_A_SUM
	} state_t;

	state_t                   state_q;
	logic                     axis_q;
	logic [COORD_BITS-1:0]    col_q;
	logic [COORD_BITS-1:0]    row_q;
	afpm_tag_t                tag_q;
	logic signed [PROD_W-1:0] prod0_q;
	logic signed [PROD_W-1:0] prod1_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [31:0]       cs_x_q;
	logic signed [31:0]       cs_y_q;
	logic [COORD_BITS-1:0]    x_q;
	logic [COORD_BITS-1:0]    y_q;
	logic                     out_valid_q;
	afpm_dst_t                out_q;

	logic signed [31:0]       coef_a;
	logic signed [31:0]       coef_b;
	logic signed [31:0]       shift_sel;
	logic signed [31:0]       cs_sel;
	logic [COORD_BITS-1:0]    dsize;
	logic [COORD_BITS-1:0]    src_w;
	logic [COORD_BITS-1:0]    src_h;
	logic [STRIDE_W-1:0]      stride;
	logic signed [31:0]       mul_a0;
	logic signed [31:0]       mul_a1;
	logic [COORD_BITS-1:0]    mul_b0;
	logic [COORD_BITS-1:0]    mul_b1;
	logic signed [PROD_W-1:0] prod0_d;
	logic signed [PROD_W-1:0] prod1_d;
	logic signed [SUM_W-1:0]  p0_w;
	logic signed [SUM_W-1:0]  p1_w;
	logic signed [SUM_W-1:0]  sh_w;
	logic signed [SUM_W-1:0]  cs_w;
	logic signed [SUM_W-1:0]  dsz_w;
	logic signed [SUM_W-1:0]  n_d;
	logic signed [SUM_W-1:0]  n_bias;
	logic signed [SUM_W-1:0]  t_d;
	logic signed [SUM_W:0]    r_d;
	logic signed [31:0]       r_sat;
	logic signed [SUM_W-1:0]  v_d;
	logic signed [SUM_W-1:0]  top_w;
	logic [COORD_BITS-1:0]    coord_d;
	logic                     out_load;
	logic [ADDR_W-1:0]        addr_d;

	always_comb begin
		coef_a    = axis_q ? cfg.coef_yx : cfg.coef_xx;
		coef_b    = axis_q ? cfg.coef_yy : cfg.coef_xy;
		shift_sel = axis_q ? cfg.shift_y : cfg.shift_x;
		cs_sel    = axis_q ? cs_y_q : cs_x_q;
		dsize     = axis_q ? cfg.dest_geometry[HEIGHT_LSB +: COORD_BITS]
		                   : cfg.dest_geometry[COORD_BITS-1:0];
		src_w     = cfg.source_size[COORD_BITS-1:0];
		src_h     = cfg.source_size[HEIGHT_LSB +: COORD_BITS];
		stride    = cfg.dest_geometry[STRIDE_LSB +: STRIDE_W];

		// Operand selection for the shared multiplier pair.
		mul_a0 = coef_a;
		mul_a1 = coef_b;
		mul_b0 = col_q;
		mul_b1 = row_q;
		if (state_q == ST_C_MUL) begin
			mul_b0 = src_w;
			mul_b1 = src_h;
		end else if (state_q == ST_A_MUL) begin
			mul_a0 = $signed(32'(stride));
			mul_b0 = y_q;
		end
		prod0_d = mul_a0 * $signed({1'b0, mul_b0});
		prod1_d = mul_a1 * $signed({1'b0, mul_b1});

		p0_w  = {{(SUM_W-PROD_W){prod0_q[PROD_W-1]}}, prod0_q};
		p1_w  = {{(SUM_W-PROD_W){prod1_q[PROD_W-1]}}, prod1_q};
		sh_w  = {{(SUM_W-32){shift_sel[31]}}, shift_sel};
		cs_w  = {{(SUM_W-32){cs_sel[31]}}, cs_sel};
		dsz_w = $signed(SUM_W'(dsize) << FRAC_BITS);

		// Centring numerator in units of half a destination pixel step.
		n_d = dsz_w - (p0_w + p1_w + (sh_w <<< 1)) + ONE_W;

		// Division by two pixel steps, rounding toward zero, scaled back up.
		n_bias = sum_q + (sum_q[SUM_W-1] ? BIAS_W : '0);
		t_d    = (n_bias >>> (FRAC_BITS + 1)) <<< FRAC_BITS;

		// Centred translation, saturated to the 32-bit signed range.
		r_d = {sum_q[SUM_W-1], sum_q} + {{(SUM_W+1-32){shift_sel[31]}}, shift_sel};
		if ((&r_d[SUM_W:31]) || !(|r_d[SUM_W:31])) begin
			r_sat = r_d[31:0];
		end else begin
			r_sat = r_d[SUM_W] ? INT32_MIN : INT32_MAX;
		end

		// Mapping and clamp to the destination.
		v_d   = p0_w + p1_w + cs_w;
		top_w = (dsize == '0) ? '0
		                      : $signed(SUM_W'(dsize - COORD_BITS'(1)) << FRAC_BITS);
		if (sum_q[SUM_W-1]) begin
			coord_d = '0;
		end else if (sum_q > top_w) begin
			coord_d = top_w[FRAC_BITS +: COORD_BITS];
		end else begin
			coord_d = sum_q[FRAC_BITS +: COORD_BITS];
		end

		addr_d   = prod0_q[ADDR_W-1:0] + ADDR_W'({x_q, 2'b00});
		out_load = (state_q == ST_A_SUM) && (!out_valid_q || pop);
		q_rd     = (state_q == ST_IDLE) && !q_empty;
		empty    = !out_valid_q;
		dest     = out_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_q      <= 1'b0;
			out_valid_q <= 1'b0;
			cs_x_q      <= '0;
			cs_y_q      <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (q_rd) begin
						col_q   <= col;
						row_q   <= row;
						tag_q   <= tag;
						axis_q  <= 1'b0;
						state_q <= tag.first ? ST_C_MUL : ST_M_MUL;
					end
				end
				ST_C_MUL: begin
					prod0_q <= prod0_d;
					prod1_q <= prod1_d;
					state_q <= ST_C_SUM;
				end
				ST_C_SUM: begin
					sum_q   <= n_d;
					state_q <= ST_C_DIV;
				end
				ST_C_DIV: begin
					sum_q   <= t_d;
					state_q <= ST_C_SAT;
				end
				ST_C_SAT: begin
					if (!axis_q) begin
						cs_x_q  <= r_sat;
						axis_q  <= 1'b1;
						state_q <= ST_C_MUL;
					end else begin
						cs_y_q  <= r_sat;
						axis_q  <= 1'b0;
						state_q <= ST_M_MUL;
					end
				end
				ST_M_MUL: begin
					prod0_q <= prod0_d;
					prod1_q <= prod1_d;
					state_q <= ST_M_SUM;
				end
				ST_M_SUM: begin
					sum_q   <= v_d;
					state_q <= ST_M_CLP;
				end
				ST_M_CLP: begin
					if (!axis_q) begin
						x_q     <= coord_d;
						axis_q  <= 1'b1;
						state_q <= ST_M_MUL;
					end else begin
						y_q     <= coord_d;
						axis_q  <= 1'b0;
						state_q <= ST_A_MUL;
					end
				end
				ST_A_MUL: begin
					prod0_q <= prod0_d;
					state_q <= ST_A_SUM;
				end
				ST_A_SUM: begin
					if (out_load) begin
						out_q.dest_address <= addr_d;
						out_q.red_out      <= tag_q.pix.red_in;
						out_q.green_out    <= tag_q.pix.green_in;
						out_q.blue_out     <= tag_q.pix.blue_in;
						out_q.alpha_out    <= ALPHA_OPAQUE;
						out_q.frame_last   <= tag_q.last;
						state_q            <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/affine_forward_pixel_mapper.sv]
// Top level of the affine forward pixel mapper: configuration registers,
// front end, decoupling queue and back end. Depends on afpm_pkg,
// afpm_front, afpm_queue and afpm_back.
//
// Usage. Source pixels enter in raster order through a queue-like port:
// a word is taken at a clock edge with push high and full low. Results leave
// through a second queue-like port: while empty is low the oldest result word
// is on dest, and it is taken at an edge with pop high. Every source pixel
// yields exactly one result word, in order.
// Configuration goes through its own valid/ready channel (ready is always
// high); cfg_index selects the register in the order coef_xx, coef_xy,
// shift_x, coef_yx, coef_yy, shift_y, source_size, dest_geometry. Write it
// only while no pixel is in flight.
// The back end runs one pixel at a time through a sequencer built around one
// pair of 32-bit multipliers and takes no new pixel until the result of the
// last one is in the output register; for the first pixel of a frame it also
// works out the centring offsets. The front end keeps accepting pixels into a
// queue of QUEUE_DEPTH words while the back end works, and a finished result
// waits in the output register while the receiver stalls. Full rises once
// the queue holds QUEUE_DEPTH words.
// Reset clears the raster counters and the queue, empties the output register,
// clears the centring state, and loads the identity matrix with zero sizes.
module affine_forward_pixel_mapper #(
	parameter int COORD_BITS  = 16,
	parameter int FRAC_BITS   = 16,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  afpm_pkg::afpm_src_t                  source,
	input  logic                                 pop,
	output logic                                 empty,
	output afpm_pkg::afpm_dst_t                  dest,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [afpm_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [afpm_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import afpm_pkg::*;

	localparam int Q_W = 2 * COORD_BITS + $bits(afpm_tag_t);

	afpm_cfg_t             cfg_q;
	logic                  q_wr;
	logic                  q_rd;
	logic                  q_full;
	logic                  q_empty;
	logic [Q_W-1:0]        q_wdata;
	logic [Q_W-1:0]        q_rdata;
	logic [COORD_BITS-1:0] f_col;
	logic [COORD_BITS-1:0] f_row;
	afpm_tag_t             f_tag;
	logic [COORD_BITS-1:0] b_col;
	logic [COORD_BITS-1:0] b_row;
	afpm_tag_t             b_tag;

	// The register file always takes a write; the block is quiet by contract.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (afpm_reg_t'(cfg_index))
				REG_COEF_XX:       cfg_q.coef_xx       <= $signed(cfg_data[31:0]);
				REG_COEF_XY:       cfg_q.coef_xy       <= $signed(cfg_data[31:0]);
				REG_SHIFT_X:       cfg_q.shift_x       <= $signed(cfg_data[31:0]);
				REG_COEF_YX:       cfg_q.coef_yx       <= $signed(cfg_data[31:0]);
				REG_COEF_YY:       cfg_q.coef_yy       <= $signed(cfg_data[31:0]);
				REG_SHIFT_Y:       cfg_q.shift_y       <= $signed(cfg_data[31:0]);
				REG_SOURCE_SIZE:   cfg_q.source_size   <= cfg_data[31:0];
				REG_DEST_GEOMETRY: cfg_q.dest_geometry <= cfg_data;
			endcase
		end
	end

	// Front end: raster position and frame marks for each accepted pixel.
	afpm_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.q_full      (q_full),
		.source      (source),
		.source_size (cfg_q.source_size),
		.q_wr        (q_wr),
		.col         (f_col),
		.row         (f_row),
		.tag         (f_tag)
	);

	assign full    = q_full;
	assign q_wdata = {f_col, f_row, f_tag};

	afpm_queue #(
		.WIDTH (Q_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (q_wdata),
		.rd     (q_rd),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	assign b_col = q_rdata[Q_W-1 -: COORD_BITS];
	assign b_row = q_rdata[Q_W-COORD_BITS-1 -: COORD_BITS];
	assign b_tag = afpm_tag_t'(q_rdata[$bits(afpm_tag_t)-1:0]);

	// Back end: centring, mapping, clamping and the output register.
	afpm_back #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_rd    (q_rd),
		.col     (b_col),
		.row     (b_row),
		.tag     (b_tag),
		.cfg     (cfg_q),
		.pop     (pop),
		.empty   (empty),
		.dest    (dest)
	);

endmodule

[rtl/afpm_checker.sv]
// Port-level checks of the affine forward pixel mapper, bound to the top level.
// Depends on afpm_pkg and affine_forward_pixel_mapper.
module afpm_props (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             push,
	input logic                             full,
	input logic                             pop,
	input logic                             empty,
	input afpm_pkg::afpm_dst_t              dest
);
	import afpm_pkg::*;

	// While reset is held the result port reads as empty and the input port as not full.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> (empty && !full))
		else $error("queue flags not cleared in reset");

	// Every result word carries an opaque alpha byte.
	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (dest.alpha_out == ALPHA_OPAQUE))
		else $error("alpha byte not opaque");

	// A waiting result word stays put until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(dest)))
		else $error("result word changed while stalled");

	// The input queue can only fill up as the result of a write.
	a_full_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("full rose without a push");

endmodule

bind affine_forward_pixel_mapper afpm_props u_checker (.*);
